// ===== src/isolated_pixel_cleanup_unit_assert.svh =====
// assertion macros used by the isolated pixel cleanup control module
`ifndef ISOLATED_PIXEL_CLEANUP_UNIT_ASSERT_SVH
`define ISOLATED_PIXEL_CLEANUP_UNIT_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define IPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("ipc assertion failed");

// consequent must hold in the same cycle as the antecedent
`define IPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipc assertion failed");

`endif

// ===== src/ipc_pkg.sv =====
// shared constants, types and helper functions of the isolated pixel cleanup unit
`default_nettype none

package ipc_pkg;

    // geometry limits
    localparam int MAX_COLUMN_LENGTH = 1024;
    localparam int ROW_W             = $clog2(MAX_COLUMN_LENGTH);
    localparam int HGT_W             = ROW_W + 1;
    localparam int PEND_W            = $clog2(MAX_COLUMN_LENGTH + 3);

    // field and register widths
    localparam int PIX_W     = 24;
    localparam int LEN_W     = 11;
    localparam int COL_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [PIX_W-1:0] WHITE_PIXEL         = '1;
    localparam logic [LEN_W-1:0] RESET_COLUMN_LENGTH = 11'd1024;
    localparam logic [COL_W-1:0] RESET_COLUMN_COUNT  = 16'd640;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN_LENGTH = 1'b0,
        CFG_COLUMN_COUNT  = 1'b1
    } t_cfg_index;

    // control handed from the address stage to the filter stage
    typedef struct packed {
        logic             read;
        logic             emit;
        logic             interior;
        logic             last;
        logic [ROW_W-1:0] row;
        logic             dn_right;
        logic             right;
        logic             up_right;
    } t_stage;

    // column length clamped to the supported range
    function automatic logic [HGT_W-1:0] eff_height(input logic [LEN_W-1:0] len);
        logic [HGT_W-1:0] h;
        if (int'(len) < 3) begin
            h = HGT_W'(3);
        end else if (int'(len) > MAX_COLUMN_LENGTH) begin
            h = HGT_W'(MAX_COLUMN_LENGTH);
        end else begin
            h = HGT_W'(len);
        end
        return h;
    endfunction

    // column count raised to the minimum of three
    function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] cnt);
        logic [COL_W-1:0] w;
        if (cnt < COL_W'(3)) begin
            w = COL_W'(3);
        end else begin
            w = cnt;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/ipc_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module ipc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/ipc_ctrl.sv =====
// input and output position tracking, ram addressing and filter stage control
`default_nettype none
`include "isolated_pixel_cleanup_unit_assert.svh"

module ipc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ipc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_cmd,
    input  logic                          i_pixel_nz,
    input  logic                          i_hold,
    output logic                          o_in_stall,
    output logic                          o_pix_we,
    output logic [ipc_pkg::ROW_W-1:0]     o_pix_waddr,
    output logic                          o_pix_re,
    output logic [ipc_pkg::ROW_W-1:0]     o_pix_raddr,
    output logic                          o_flag_re,
    output logic [ipc_pkg::ROW_W-1:0]     o_flag_raddr,
    output ipc_pkg::t_stage               o_stage
);

    localparam int ROW_W  = ipc_pkg::ROW_W;
    localparam int HGT_W  = ipc_pkg::HGT_W;
    localparam int COL_W  = ipc_pkg::COL_W;
    localparam int PEND_W = ipc_pkg::PEND_W;

    logic [HGT_W-1:0]  r_h, n_h;
    logic [COL_W-1:0]  r_w, n_w;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_done, n_done;
    logic [PEND_W-1:0] r_pending, n_pending;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic              r_last1, n_last1;
    logic              r_last2, n_last2;
    ipc_pkg::t_stage   r_stage, n_stage;

    logic              accept;
    logic              is_pix;
    logic              pix_emit;
    logic              drn_emit;
    logic              emit;
    logic              reads;
    logic [HGT_W-1:0]  h_m1;
    logic [COL_W-1:0]  w_m1;
    logic              in_row_last;
    logic              in_col_last;
    logic              out_row_last;
    logic              out_col_last;
    logic              frame_last;
    logic              interior;
    logic [ROW_W-1:0]  out_row_next;

    // item classification
    assign accept   = i_in_valid && !i_hold;
    assign is_pix   = !i_cmd && !r_done;
    assign pix_emit = is_pix && (r_pending == (PEND_W'(r_h) + PEND_W'(1)));
    assign drn_emit = !is_pix && r_done && (r_pending != '0);
    assign emit     = pix_emit || drn_emit;
    assign reads    = is_pix || drn_emit;

    // position decode
    assign h_m1         = r_h - HGT_W'(1);
    assign w_m1         = r_w - COL_W'(1);
    assign in_row_last  = (HGT_W'(r_row) == h_m1);
    assign in_col_last  = (r_col == w_m1);
    assign out_row_last = (HGT_W'(r_out_row) == h_m1);
    assign out_col_last = (r_out_col == w_m1);
    assign frame_last   = out_row_last && out_col_last;
    assign interior     = (r_out_col != '0) && (r_out_row != '0)
                          && !out_col_last && !out_row_last;
    assign out_row_next = out_row_last ? '0 : r_out_row + ROW_W'(1);

    // next state of counters and stage register
    always_comb begin
        n_h       = r_h;
        n_w       = r_w;
        n_row     = r_row;
        n_col     = r_col;
        n_done    = r_done;
        n_pending = r_pending;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_last1   = r_last1;
        n_last2   = r_last2;
        n_stage   = r_stage;

        if (accept && is_pix) begin
            n_last1 = i_pixel_nz;
            n_last2 = r_last1;
            if (in_col_last && in_row_last) begin
                n_done = 1'b1;
            end else if (in_row_last) begin
                n_row = '0;
                n_col = r_col + COL_W'(1);
            end else begin
                n_row = r_row + ROW_W'(1);
            end
            if (!pix_emit) begin
                n_pending = r_pending + PEND_W'(1);
            end
        end

        if (accept && drn_emit) begin
            n_pending = r_pending - PEND_W'(1);
        end

        if (accept && emit) begin
            if (frame_last) begin
                n_row     = '0;
                n_col     = '0;
                n_done    = 1'b0;
                n_pending = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else begin
                n_out_row = out_row_next;
                if (out_row_last) begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end

        if (!i_hold) begin
            n_stage.read     = accept && reads;
            n_stage.emit     = accept && emit;
            n_stage.interior = interior;
            n_stage.last     = frame_last;
            n_stage.row      = r_out_row;
            n_stage.dn_right = i_pixel_nz;
            n_stage.right    = r_last1;
            n_stage.up_right = r_last2;
        end

        // a register write restarts the frame
        if (i_cfg_we) begin
            unique case (ipc_pkg::t_cfg_index'(i_cfg_index))
                ipc_pkg::CFG_COLUMN_LENGTH: begin
                    n_h = ipc_pkg::eff_height(i_cfg_data[ipc_pkg::LEN_W-1:0]);
                end
                ipc_pkg::CFG_COLUMN_COUNT: begin
                    n_w = ipc_pkg::eff_width(i_cfg_data[COL_W-1:0]);
                end
                default: begin
                    n_h = r_h;
                end
            endcase
            n_row     = '0;
            n_col     = '0;
            n_done    = 1'b0;
            n_pending = '0;
            n_out_row = '0;
            n_out_col = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h       <= ipc_pkg::eff_height(ipc_pkg::RESET_COLUMN_LENGTH);
            r_w       <= ipc_pkg::eff_width(ipc_pkg::RESET_COLUMN_COUNT);
            r_row     <= '0;
            r_col     <= '0;
            r_done    <= 1'b0;
            r_pending <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_stage   <= '0;
        end else begin
            r_h       <= n_h;
            r_w       <= n_w;
            r_row     <= n_row;
            r_col     <= n_col;
            r_done    <= n_done;
            r_pending <= n_pending;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_stage   <= n_stage;
        end
    end

    // nonzero flags of the two latest pixels
    always_ff @(posedge i_clk) begin
        r_last1 <= n_last1;
        r_last2 <= n_last2;
    end

    // ram addressing: pixels go to their row, the read fetches the next result row
    assign o_in_stall   = i_hold;
    assign o_pix_we     = accept && is_pix;
    assign o_pix_waddr  = r_row;
    assign o_pix_re     = accept && reads;
    assign o_pix_raddr  = is_pix ? r_row : out_row_next;
    assign o_flag_re    = accept && emit;
    assign o_flag_raddr = out_row_next;
    assign o_stage      = r_stage;

    // checks
    `IPC_ASSERT_ALWAYS(a_pending_bound, i_clk, i_rst_n, r_pending <= (PEND_W'(r_h) + PEND_W'(1)))
    `IPC_ASSERT_IMPLY(a_done_has_pending, i_clk, i_rst_n, r_done, r_pending != '0)
    `IPC_ASSERT_IMPLY(a_emit_reads, i_clk, i_rst_n, r_stage.emit, r_stage.read)
    `IPC_ASSERT_IMPLY(a_last_is_border, i_clk, i_rst_n, r_stage.emit && r_stage.last, !r_stage.interior)

endmodule

`default_nettype wire

// ===== src/ipc_filter.sv =====
// 3x3 isolated pixel decision, neighbour flag history and output register
`default_nettype none

module ipc_filter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ipc_pkg::t_stage           i_stage,
    input  logic [ipc_pkg::PIX_W-1:0] i_pix_rdata,
    input  logic                      i_flag_rdata,
    input  logic                      i_out_stall,
    output logic                      o_hold,
    output logic                      o_flag_we,
    output logic [ipc_pkg::ROW_W-1:0] o_flag_waddr,
    output logic                      o_flag_wdata,
    output logic                      o_out_valid,
    output logic [ipc_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_frame_end
);

    localparam int PIX_W = ipc_pkg::PIX_W;

    logic [PIX_W-1:0] r_held;
    logic             r_up;
    logic             r_left;
    logic             r_up_left;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_pixel_out;
    logic             r_frame_end;

    logic             out_free;
    logic             hold;
    logic [7:0]       nb;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] result;

    // output register frees up when empty or being taken
    assign out_free = !r_out_valid || !i_out_stall;
    assign hold     = i_stage.emit && !out_free;

    // neighbourhood: left column and up are cleaned flags, the rest received pixels
    assign nb = {r_up, r_up_left, r_left, i_flag_rdata, (i_pix_rdata != '0),
                 i_stage.up_right, i_stage.right, i_stage.dn_right};
    assign center = r_held;

    // isolated pixel decision
    always_comb begin
        result = center;
        if (i_stage.interior) begin
            if ((center == '0) && (&nb)) begin
                result = ipc_pkg::WHITE_PIXEL;
            end else if ((center != '0) && !(|nb)) begin
                result = '0;
            end
        end
    end

    // cleaned flag goes back to the flag store at the result's row
    assign o_flag_we    = i_stage.emit && !hold;
    assign o_flag_waddr = i_stage.row;
    assign o_flag_wdata = (result != '0);

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_stage.emit;
        end
    end

    // result payload, held centre pixel and flag history
    always_ff @(posedge i_clk) begin
        if (out_free && i_stage.emit) begin
            r_pixel_out <= result;
            r_frame_end <= i_stage.last;
        end
        if (i_stage.read && !hold) begin
            r_held <= i_pix_rdata;
        end
        if (i_stage.emit && !hold) begin
            r_up      <= (result != '0);
            r_up_left <= r_left;
            r_left    <= i_flag_rdata;
        end
    end

    assign o_hold      = hold;
    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_frame_end = r_frame_end;

endmodule

`default_nettype wire

// ===== src/isolated_pixel_cleanup_unit.sv =====
// top level of the isolated pixel cleanup unit
// Cleans salt-and-pepper noise from a frame of 24-bit pixels streamed in
// column-major order, one item per clock. An interior zero pixel with all
// eight neighbours nonzero becomes white, an interior nonzero pixel with all
// eight neighbours zero becomes 0; border pixels pass through. Left and upper
// neighbours are the cleaned values, right and lower ones the received values.
// The column delay ram read is registered, the
// decision is made in one stage and lands in the output register, so a new
// item is taken every clock unless the output register is full and stalled.
// A result appears once one column plus one pixel of later pixels has been
// received; the last column length plus one results of a frame are released
// by drain items (cmd = 1), one each, and frame_end marks the last pixel.
// Drains before the frame is complete give no result, and pixels sent while
// the tail is still pending are dropped and act as drains. Writing a
// configuration register restarts the frame. No clearing pass after reset.
`default_nettype none

module isolated_pixel_cleanup_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ipc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [ipc_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ipc_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_frame_end
);

    localparam int ROW_W = ipc_pkg::ROW_W;
    localparam int PIX_W = ipc_pkg::PIX_W;

    logic             hold;
    logic             pix_we;
    logic [ROW_W-1:0] pix_waddr;
    logic             pix_re;
    logic [ROW_W-1:0] pix_raddr;
    logic [PIX_W-1:0] pix_rdata;
    logic             flag_re;
    logic [ROW_W-1:0] flag_raddr;
    logic             flag_rdata;
    logic             flag_we;
    logic [ROW_W-1:0] flag_waddr;
    logic             flag_wdata;
    ipc_pkg::t_stage  stage;

    // position tracking and ram addressing
    ipc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_cmd        (i_cmd),
        .i_pixel_nz   (i_pixel_in != '0),
        .i_hold       (hold),
        .o_in_stall   (o_in_stall),
        .o_pix_we     (pix_we),
        .o_pix_waddr  (pix_waddr),
        .o_pix_re     (pix_re),
        .o_pix_raddr  (pix_raddr),
        .o_flag_re    (flag_re),
        .o_flag_raddr (flag_raddr),
        .o_stage      (stage)
    );

    // one column of received pixels
    ipc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (ipc_pkg::MAX_COLUMN_LENGTH)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (i_pixel_in),
        .i_re    (pix_re),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    // one column of cleaned nonzero flags
    ipc_ram #(
        .WIDTH (1),
        .DEPTH (ipc_pkg::MAX_COLUMN_LENGTH)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_re    (flag_re),
        .i_raddr (flag_raddr),
        .o_rdata (flag_rdata)
    );

    // decision and output register
    ipc_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (stage),
        .i_pix_rdata  (pix_rdata),
        .i_flag_rdata (flag_rdata),
        .i_out_stall  (i_out_stall),
        .o_hold       (hold),
        .o_flag_we    (flag_we),
        .o_flag_waddr (flag_waddr),
        .o_flag_wdata (flag_wdata),
        .o_out_valid  (o_out_valid),
        .o_pixel_out  (o_pixel_out),
        .o_frame_end  (o_frame_end)
    );

endmodule

`default_nettype wire
